/* rtl/core/srr_pkg.sv */
`timescale 1ns / 1ps

package srr_pkg;

    localparam int SEQ_SPACE = 128;
    localparam int SEQ_W     = $clog2(SEQ_SPACE);
    localparam int WIN_W     = 6;
    localparam int HANDLE_W  = 10;
    localparam int BYTES_W   = 8;

    localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(32);

    // longest run of held slots drained after one in-order packet
    localparam int DRAIN_LIMIT = 62;
    localparam int GUARD_W     = $clog2(DRAIN_LIMIT + 1);

    localparam logic [1:0] CMD_ACK   = 2'd0;
    localparam logic [1:0] CMD_STORE = 2'd1;
    localparam logic [1:0] CMD_RUN   = 2'd2;

    localparam logic KIND_DELIVER = 1'b0;
    localparam logic KIND_ACK     = 1'b1;

    typedef struct packed {
        logic [SEQ_W-1:0]    seq_number;
        logic                ends_message;
        logic                checksum_ok;
        logic [HANDLE_W-1:0] payload_handle;
        logic [BYTES_W-1:0]  payload_bytes;
    } pkt_t;

    typedef struct packed {
        logic                result_kind;
        logic [SEQ_W-1:0]    result_seq;
        logic [HANDLE_W-1:0] out_handle;
        logic [BYTES_W-1:0]  out_bytes;
        logic                out_ends_message;
        logic                run_last;
    } result_t;

    typedef struct packed {
        logic [1:0]          op;
        logic [SEQ_W-1:0]    seq;
        logic                ends;
        logic [HANDLE_W-1:0] handle;
        logic [BYTES_W-1:0]  bytes;
    } cmd_t;

    typedef struct packed {
        logic not_empty;
        logic full;
    } q_status_t;

    typedef struct packed {
        logic                ends;
        logic [HANDLE_W-1:0] handle;
        logic [BYTES_W-1:0]  bytes;
    } slot_t;

endpackage

/* rtl/core/srr_front.sv */
`timescale 1ns / 1ps

module srr_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      take,
    input  srr_pkg::pkt_t             packet,
    input  logic                      cfg_we,
    input  logic [srr_pkg::WIN_W-1:0] cfg_wdata,
    input  logic [srr_pkg::SEQ_W-1:0] expected,
    input  srr_pkg::q_status_t        q_stat,
    output logic                      pending,
    output logic                      push,
    output srr_pkg::cmd_t             cmd
);
    import srr_pkg::*;

    logic [WIN_W-1:0] window_reg;
    logic             pend_reg;
    pkt_t             pkt_reg;
    logic [SEQ_W-1:0] offset;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= WINDOW_RESET;
        end
        else if (cfg_we)
        begin
            window_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
        end
        else if (take)
        begin
            pend_reg <= 1'b1;
        end
        else if (pend_reg && !q_stat.full)
        begin
            pend_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            pkt_reg <= packet;
        end
    end

    // distance from the expected number, wrapped in the sequence space
    assign offset = pkt_reg.seq_number - expected;

    always_comb
    begin
        cmd.seq    = pkt_reg.seq_number;
        cmd.ends   = pkt_reg.ends_message;
        cmd.handle = pkt_reg.payload_handle;
        cmd.bytes  = pkt_reg.payload_bytes;
        if (offset >= {1'b0, window_reg})
        begin
            cmd.op = CMD_ACK;
        end
        else if (offset == '0)
        begin
            cmd.op = CMD_RUN;
        end
        else
        begin
            cmd.op = CMD_STORE;
        end
    end

    // drop a packet with a failed checksum here
    assign push    = pend_reg && !q_stat.full && pkt_reg.checksum_ok;
    assign pending = pend_reg;

endmodule

/* rtl/core/srr_queue.sv */
`timescale 1ns / 1ps

module srr_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  srr_pkg::cmd_t      push_cmd,
    input  logic               pop,
    output srr_pkg::cmd_t      head,
    output srr_pkg::q_status_t stat
);
    import srr_pkg::*;

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign do_push = push && (count_reg != 2'd2);
    assign do_pop  = pop && (count_reg != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign head           = entry_reg[rd_ptr_reg];
    assign stat.not_empty = (count_reg != 2'd0);
    assign stat.full      = (count_reg == 2'd2);

endmodule

/* rtl/core/srr_back.sv */
`timescale 1ns / 1ps

module srr_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  srr_pkg::cmd_t             head,
    input  srr_pkg::q_status_t        q_stat,
    output logic                      pop,
    output logic [srr_pkg::SEQ_W-1:0] expected,
    output logic                      active,
    output logic                      result_valid,
    output srr_pkg::result_t          result
);
    import srr_pkg::*;

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_DRAIN = 1'b1;

    logic                 state_reg, state_next;
    logic [SEQ_W-1:0]     exp_reg, exp_next;
    logic [GUARD_W-1:0]   guard_reg, guard_next;
    logic [SEQ_SPACE-1:0] held_reg;
    slot_t                slot_mem [SEQ_SPACE];
    slot_t                rd_reg;
    logic                 set_held;
    logic                 clr_held;
    logic                 can_drain;
    logic                 res_valid_reg, res_valid_next;
    result_t              res_reg, res_next;

    assign pop       = (state_reg == ST_IDLE) && q_stat.not_empty;
    assign can_drain = held_reg[exp_reg] && (guard_reg != GUARD_W'(DRAIN_LIMIT));

    always_comb
    begin
        state_next     = state_reg;
        exp_next       = exp_reg;
        guard_next     = guard_reg;
        set_held       = 1'b0;
        clr_held       = 1'b0;
        res_valid_next = 1'b0;
        res_next       = '0;
        res_next.result_kind = KIND_ACK;
        res_next.result_seq  = exp_reg - SEQ_W'(1);
        res_next.run_last    = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    case (head.op)
                        CMD_ACK:
                        begin
                            res_valid_next = 1'b1;
                        end
                        CMD_STORE:
                        begin
                            // hold once; drop a duplicate
                            set_held = !held_reg[head.seq];
                        end
                        CMD_RUN:
                        begin
                            res_valid_next            = 1'b1;
                            res_next.result_kind      = KIND_DELIVER;
                            res_next.result_seq       = head.seq;
                            res_next.out_handle       = head.handle;
                            res_next.out_bytes        = head.bytes;
                            res_next.out_ends_message = head.ends;
                            res_next.run_last         = 1'b0;
                            exp_next                  = exp_reg + SEQ_W'(1);
                            guard_next                = '0;
                            state_next                = ST_DRAIN;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_DRAIN:
            begin
                res_valid_next = 1'b1;
                if (can_drain)
                begin
                    res_next.result_kind      = KIND_DELIVER;
                    res_next.result_seq       = exp_reg;
                    res_next.out_handle       = rd_reg.handle;
                    res_next.out_bytes        = rd_reg.bytes;
                    res_next.out_ends_message = rd_reg.ends;
                    res_next.run_last         = 1'b0;
                    clr_held                  = 1'b1;
                    exp_next                  = exp_reg + SEQ_W'(1);
                    guard_next                = guard_reg + GUARD_W'(1);
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            exp_reg       <= '0;
            guard_reg     <= '0;
            held_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            exp_reg       <= exp_next;
            guard_reg     <= guard_next;
            res_valid_reg <= res_valid_next;
            if (set_held)
            begin
                held_reg[head.seq] <= 1'b1;
            end
            if (clr_held)
            begin
                held_reg[exp_reg] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    // read ahead at the next expected number so the drain runs one per cycle
    always_ff @(posedge clk)
    begin
        if (set_held)
        begin
            slot_mem[head.seq] <= '{ends: head.ends, handle: head.handle, bytes: head.bytes};
        end
        rd_reg <= slot_mem[exp_next];
    end

    assign expected     = exp_reg;
    assign active       = (state_reg == ST_DRAIN);
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    a_guard_bound: assert property (@(posedge clk) disable iff (!rst_n)
        guard_reg <= GUARD_W'(DRAIN_LIMIT))
        else $error("drain count past its limit");

    a_drain_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN) && can_drain |=> !held_reg[$past(exp_reg)])
        else $error("drained slot still held");

    a_deliver_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.result_kind == KIND_DELIVER) |-> !result.run_last)
        else $error("delivery marked as last of run");

    a_ack_empty: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.result_kind == KIND_ACK) |->
            (result.out_handle == '0) && (result.out_bytes == '0)
            && !result.out_ends_message && result.run_last)
        else $error("ack carries payload fields");

    a_drain_ends_ack: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN) && !can_drain |=> result_valid
            && (result.result_kind == KIND_ACK) && (state_reg == ST_IDLE))
        else $error("drain did not close with an ack");

endmodule

/* rtl/core/selective_repeat_receiver.sv */
`timescale 1ns / 1ps

// Selective-repeat ARQ receive side. Raise start with a packet while busy is
// low and it is taken at that edge. Every result appears on result for exactly
// one cycle with result_valid high; the receiver cannot stall it, so sample
// it whenever result_valid is set. A packet with a failed checksum gives no
// result. A packet outside [expected, expected+window) gives a single ack for
// expected-1. An out-of-order packet inside the window is held (a duplicate
// is dropped) with no result. The in-order packet is delivered, then each
// held successor in order, one per cycle, then one ack with run_last set.
// Timing: a packet passes the registered classifying front and then the
// command queue, where the back end takes it; busy stays high until then for
// a packet that is held or acked (or until it leaves the front, for a failed
// checksum), and an ack appears in the same cycle that busy drops. An in-order
// packet keeps busy high while its held successors drain and the closing ack
// is formed; its delivery appears in the cycle after the back end takes it
// and the closing ack in the same cycle that busy drops.
// The drain rate is set by the slot memory, read one entry ahead at the
// next expected number. The window width resets to 32; write it through
// cfg_we and cfg_wdata only while busy is low and no result is pending.
module selective_repeat_receiver (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  srr_pkg::pkt_t             packet,
    input  logic                      cfg_we,
    input  logic [srr_pkg::WIN_W-1:0] cfg_wdata,
    output logic                      result_valid,
    output srr_pkg::result_t          result
);
    import srr_pkg::*;

    logic             take;
    logic             front_pending;
    logic             q_push;
    logic             q_pop;
    cmd_t             front_cmd;
    cmd_t             q_head;
    q_status_t        q_stat;
    logic [SEQ_W-1:0] expected;
    logic             back_active;

    // hold off new packets until every stage has settled the previous one
    assign busy = front_pending || q_stat.not_empty || back_active;
    assign take = start && !busy;

    // classify each transfer against the window
    srr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .packet    (packet),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .expected  (expected),
        .q_stat    (q_stat),
        .pending   (front_pending),
        .push      (q_push),
        .cmd       (front_cmd)
    );

    // decouple classification from execution
    srr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (front_cmd),
        .pop      (q_pop),
        .head     (q_head),
        .stat     (q_stat)
    );

    // store, deliver, drain and acknowledge
    srr_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (q_head),
        .q_stat       (q_stat),
        .pop          (q_pop),
        .expected     (expected),
        .active       (back_active),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

/* bench/selective_repeat_receiver_tb.sv */
`timescale 1ns / 1ps

// Self-checking bench for the selective-repeat receive side. Packets come
// from a plan queue filled up front; each accepted transfer is run through a
// predictor of the receive window, which queues the deliveries and acks the
// block owes. Every result the block strobes out is matched, field by field,
// with the oldest owed result.
module selective_repeat_receiver_tb;
    import srr_pkg::*;

    typedef enum logic [1:0] {ITEM_PACKET, ITEM_WINDOW, ITEM_SETTLE} plan_kind_t;

    typedef struct {
        plan_kind_t       kind;
        pkt_t             pkt;
        logic [WIN_W-1:0] win;
    } plan_item_t;

    localparam logic [WIN_W-1:0] WINDOW_TOP = {WIN_W{1'b1}};
    // idle cycles required before a window write or a settle point; covers
    // packets that are held or dropped and so leave no result behind
    localparam int CALM_CYCLES  = 8;
    localparam int TAIL_CYCLES  = 12;
    localparam int REPORT_LIMIT = 20;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    pkt_t             packet = '0;
    logic             cfg_we = 1'b0;
    logic [WIN_W-1:0] cfg_wdata = '0;
    logic             result_valid;
    result_t          result;

    selective_repeat_receiver uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .packet       (packet),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .result_valid (result_valid),
        .result       (result)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // Receive-window predictor: its own copy of the expected number, the
    // window width and the slots held for out-of-order packets.
    // ------------------------------------------------------------------
    logic [SEQ_W-1:0]    rx_next   = '0;
    logic [WIN_W-1:0]    rx_window = WINDOW_RESET;
    logic                held        [SEQ_SPACE] = '{default: 1'b0};
    logic                held_ends   [SEQ_SPACE] = '{default: 1'b0};
    logic [HANDLE_W-1:0] held_handle [SEQ_SPACE];
    logic [BYTES_W-1:0]  held_bytes  [SEQ_SPACE];
    result_t             owed_results [$];

    plan_item_t          plan [$];
    logic [SEQ_W-1:0]    plan_next = '0;
    int                  planned = 0;

    int gap_left = 0;
    int calm = 0;
    int packets_taken = 0;
    int windows_written = 0;
    int settles = 0;
    int slices_seen = 0;
    int acks_seen = 0;
    int run_len = 0;
    int longest_run = 0;
    int mismatches = 0;

    function automatic result_t make_result(input logic kind, input logic [SEQ_W-1:0] seq,
                                            input logic [HANDLE_W-1:0] handle,
                                            input logic [BYTES_W-1:0] bytes,
                                            input logic ends, input logic last);
        result_t r;
        r.result_kind      = kind;
        r.result_seq       = seq;
        r.out_handle       = handle;
        r.out_bytes        = bytes;
        r.out_ends_message = ends;
        r.run_last         = last;
        return r;
    endfunction

    // Append one result to the owed list.
    task automatic owe(input result_t r);
        owed_results = {owed_results, r};
    endtask

    // Work out what one accepted packet owes and advance the window.
    task automatic receive_packet(input pkt_t p);
        logic [SEQ_W-1:0] offset;
        int               drained;
        // a failed checksum leaves no trace at all
        if (!p.checksum_ok)
            return;
        // distance from the expected number, wrapped in the sequence space
        offset = p.seq_number - rx_next;
        if (offset >= {1'b0, rx_window})
        begin
            // outside the window (a zero window lets nothing in): ack the
            // number before the expected one, wrapping below zero
            owe(make_result(KIND_ACK, rx_next - SEQ_W'(1), '0, '0, 1'b0, 1'b1));
            return;
        end
        if (offset != '0)
        begin
            // ahead of time: hold it once, drop any later copy silently
            if (!held[p.seq_number])
            begin
                held[p.seq_number]        = 1'b1;
                held_ends[p.seq_number]   = p.ends_message;
                held_handle[p.seq_number] = p.payload_handle;
                held_bytes[p.seq_number]  = p.payload_bytes;
            end
            return;
        end
        // in order: deliver it, drain the held run behind it, then close with an ack
        owe(make_result(KIND_DELIVER, p.seq_number, p.payload_handle,
                        p.payload_bytes, p.ends_message, 1'b0));
        rx_next = rx_next + SEQ_W'(1);
        drained = 0;
        while (drained < DRAIN_LIMIT && held[rx_next])
        begin
            owe(make_result(KIND_DELIVER, rx_next, held_handle[rx_next],
                            held_bytes[rx_next], held_ends[rx_next], 1'b0));
            held[rx_next]      = 1'b0;
            held_ends[rx_next] = 1'b0;
            rx_next            = rx_next + SEQ_W'(1);
            drained++;
        end
        owe(make_result(KIND_ACK, rx_next - SEQ_W'(1), '0, '0, 1'b0, 1'b1));
    endtask

    // Mostly back-to-back or short pauses, now and then a long stretch.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // ------------------------------------------------------------------
    // Driver: present the next planned packet, hold start until the transfer
    // is taken, and perform window writes and settle points only once the
    // block has gone quiet.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : drive_packets
        logic nxt_start;
        logic nxt_we;
        if (!rst_n)
        begin
            start     <= 1'b0;
            packet    <= '0;
            cfg_we    <= 1'b0;
            cfg_wdata <= '0;
            gap_left  = 0;
            calm      = 0;
        end
        else
        begin
            nxt_start = start;
            nxt_we    = 1'b0;
            if (!busy && !start && owed_results.size() == 0)
                calm++;
            else
                calm = 0;
            // transfer taken at this edge: predict from the packet on the port
            if (start && !busy)
            begin
                receive_packet(packet);
                packets_taken++;
                nxt_start = 1'b0;
            end
            if (!nxt_start && plan.size() != 0)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                end
                else if (plan[0].kind == ITEM_PACKET)
                begin
                    packet    <= plan[0].pkt;
                    nxt_start = 1'b1;
                    gap_left  = pick_gap();
                    plan.delete(0);
                end
                else if (calm >= CALM_CYCLES)
                begin
                    // nothing in flight and nothing owed: safe to reconfigure
                    if (plan[0].kind == ITEM_WINDOW)
                    begin
                        nxt_we    = 1'b1;
                        cfg_wdata <= plan[0].win;
                        rx_window = plan[0].win;
                        windows_written++;
                    end
                    else
                    begin
                        settles++;
                    end
                    calm = 0;
                    plan.delete(0);
                end
            end
            start  <= nxt_start;
            cfg_we <= nxt_we;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: results cannot be held off, so take one whenever the strobe
    // is up and compare it with the oldest owed result.
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    task automatic compare_field(input string name, input logic [15:0] got,
                                 input logic [15:0] want, input logic [SEQ_W-1:0] seq);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h, expected %0h (owed seq %0d)",
                                      name, got, want, seq));
    endtask

    always @(posedge clk)
    begin : watch_results
        result_t want;
        if (rst_n && result_valid !== 1'b0)
        begin
            if (owed_results.size() == 0)
            begin
                report_mismatch($sformatf("unowed result kind %0h seq %0d",
                                          result.result_kind, result.result_seq));
            end
            else
            begin
                want = owed_results.pop_front();
                compare_field("result_kind", 16'(result.result_kind),
                              16'(want.result_kind), want.result_seq);
                compare_field("result_seq", 16'(result.result_seq),
                              16'(want.result_seq), want.result_seq);
                compare_field("out_handle", 16'(result.out_handle),
                              16'(want.out_handle), want.result_seq);
                compare_field("out_bytes", 16'(result.out_bytes),
                              16'(want.out_bytes), want.result_seq);
                compare_field("out_ends_message", 16'(result.out_ends_message),
                              16'(want.out_ends_message), want.result_seq);
                compare_field("run_last", 16'(result.run_last),
                              16'(want.run_last), want.result_seq);
                if (want.result_kind == KIND_ACK)
                    acks_seen++;
                else
                    slices_seen++;
                run_len++;
                if (want.run_last)
                begin
                    if (run_len > longest_run)
                        longest_run = run_len;
                    run_len = 0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Plan building
    // ------------------------------------------------------------------
    task automatic plan_fixed(input logic [SEQ_W-1:0] seq, input logic ends, input logic ok,
                              input logic [HANDLE_W-1:0] handle,
                              input logic [BYTES_W-1:0] bytes);
        plan_item_t it;
        it.kind                = ITEM_PACKET;
        it.win                 = '0;
        it.pkt.seq_number      = seq;
        it.pkt.ends_message    = ends;
        it.pkt.checksum_ok     = ok;
        it.pkt.payload_handle  = handle;
        it.pkt.payload_bytes   = bytes;
        plan = {plan, it};
        // packets the block ignores do not count towards the budget
        if (ok)
            planned++;
    endtask

    task automatic plan_packet(input logic [SEQ_W-1:0] seq, input logic ok);
        plan_fixed(seq, 1'($urandom_range(0, 1)), ok, HANDLE_W'($urandom_range(0, 1023)),
                   BYTES_W'($urandom_range(0, 255)));
    endtask

    task automatic plan_control(input plan_kind_t kind, input logic [WIN_W-1:0] win);
        plan_item_t it;
        it.kind = kind;
        it.win  = win;
        it.pkt  = '0;
        plan = {plan, it};
    endtask

    // A run of consecutive numbers from the planned expected one, sent in
    // any order with stray copies and bad-checksum noise mixed in. Every
    // number is sent, so the run always completes and leaves no slot held.
    // With base_last the base comes after all its successors and no noise
    // is added, which drains the longest possible run.
    task automatic plan_burst(input int span, input bit base_last);
        int order [64];
        int i;
        int pick;
        int swap;
        for (i = 0; i < span; i++)
            order[i] = base_last ? (i + 1) % span : i;
        if (!base_last && $urandom_range(0, 2) != 0)
        begin
            for (i = span - 1; i > 0; i--)
            begin
                pick        = $urandom_range(0, i);
                swap        = order[i];
                order[i]    = order[pick];
                order[pick] = swap;
            end
        end
        for (i = 0; i < span; i++)
        begin
            plan_packet(SEQ_W'(int'(plan_next) + order[i]), 1'b1);
            if (!base_last && $urandom_range(0, 7) == 0)
                plan_packet(SEQ_W'(int'(plan_next) + int'($urandom_range(0, span - 1))),
                            1'b1);
            if (!base_last && $urandom_range(0, 9) == 0)
                plan_packet(SEQ_W'($urandom_range(0, 127)), 1'b0);
        end
        plan_next = SEQ_W'(int'(plan_next) + span);
    endtask

    initial
    begin : stimulus
        logic [WIN_W-1:0] phase_window [4];
        int               phase_target [4];
        logic [WIN_W-1:0] w;
        int               p;
        int               span;

        // --- directed part, window at its reset width ---
        plan_fixed(7'd64, 1'b0, 1'b1, 10'd5, 8'd9);          // outside at zero: ack wraps
        plan_fixed(7'd0, 1'b1, 1'b0, 10'h3FF, 8'hFF);        // bad checksum: ignored
        plan_fixed(7'd0, 1'b1, 1'b1, 10'h3FF, 8'hFF);        // in order, all-ones payload
        plan_fixed(7'd3, 1'b0, 1'b1, 10'h000, 8'h00);        // held, zero length
        plan_fixed(7'd3, 1'b1, 1'b1, 10'h155, 8'hAA);        // copy of a held slot: dropped
        plan_fixed(7'd2, 1'b1, 1'b1, 10'h2AA, 8'h55);        // held
        plan_fixed(7'd1, 1'b0, 1'b1, 10'h3FF, 8'h00);        // fills the gap, drains 2 and 3
        plan_fixed(7'd36, 1'b1, 1'b1, 10'h001, 8'h01);       // just past the window
        plan_fixed(7'd3, 1'b0, 1'b1, 10'h200, 8'h80);        // behind the window
        plan_fixed(7'd127, 1'b1, 1'b1, 10'h3FF, 8'hFF);      // top of the space
        plan_control(ITEM_WINDOW, '0);                       // zero window: all acked
        plan_fixed(7'd4, 1'b1, 1'b1, 10'h0F0, 8'h0F);
        plan_fixed(7'd100, 1'b0, 1'b1, 10'h30F, 8'hF0);
        plan_control(ITEM_WINDOW, 6'd1);                     // narrowest real window
        plan_fixed(7'd5, 1'b0, 1'b1, 10'h0AA, 8'h33);
        plan_fixed(7'd4, 1'b1, 1'b1, 10'h355, 8'hCC);
        plan_next = 7'd5;

        // --- random part: completed runs under a range of widths ---
        phase_window[0] = WINDOW_TOP;
        phase_window[1] = 6'd1;
        phase_window[2] = WIN_W'($urandom_range(2, 62));
        phase_window[3] = WIN_W'($urandom_range(2, 16));
        phase_target[0] = 75;
        phase_target[1] = 88;
        phase_target[2] = 100;
        phase_target[3] = 110;
        for (p = 0; p < 4; p++)
        begin
            w = phase_window[p];
            plan_control(ITEM_WINDOW, w);
            // widest window: hold every successor, then release them all with one in-order base
            if (p == 0)
                plan_burst(int'(w), 1'b1);
            while (planned < phase_target[p])
            begin
                if (w == WIN_W'(1))
                    span = 1;
                else if ($urandom_range(0, 5) == 0)
                    span = $urandom_range(1, (w < 20) ? w : 20);
                else
                    span = $urandom_range(1, (w < 6) ? w : 6);
                plan_burst(span, 1'b0);
                if ($urandom_range(0, 3) == 0)
                    plan_packet(SEQ_W'(int'(plan_next) + int'($urandom_range(w, 127))),
                                1'b1);
                // hold the sender until everything owed has come back
                if ($urandom_range(0, 11) == 0)
                    plan_control(ITEM_SETTLE, '0);
            end
        end
        plan_control(ITEM_SETTLE, '0);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (plan.size() != 0 || start)
            @(posedge clk);
        while (owed_results.size() != 0 || busy)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("%0d packets taken across %0d window settings, %0d pauses to drain",
                 packets_taken, windows_written, settles);
        $display("%0d slices and %0d acks checked, longest run %0d results, %0d mismatches",
                 slices_seen, acks_seen, longest_run, mismatches);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial
    begin : watchdog
        #400000;
        $display("FAILURE");
        $finish;
    end

endmodule
